@@ src/lmrs_pkg.sv @@
// Package: sizes, codes, controller/datapath structs and helper functions for the row scanner.
package lmrs_pkg;

  localparam int ROWS         = 16;
  localparam int MAX_COLUMNS  = 16;
  localparam int STRIDE       = MAX_COLUMNS + 1;
  localparam int DEPTH        = ROWS * STRIDE;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int PANEL_BYTES  = 8;

  localparam int OP_W         = 2;
  localparam int ROW_W        = 4;
  localparam int STOP_W       = 5;
  localparam int COL_W        = 5;
  localparam int BYTE_W       = 8;
  localparam int AMOUNT_W     = 4;
  localparam int PANEL_W      = 2;
  localparam int INDEX_W      = 4;

  localparam logic [PANEL_W-1:0] PANEL_RESET = PANEL_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_SHIFT = 2'd1,
    OP_SCAN  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SH_PRIME,
    ST_SH_HOLD,
    ST_SH_STEP,
    ST_SH_TAIL,
    ST_SC_READ,
    ST_SC_LOAD
  } state_t;

  typedef struct packed {
    logic item_take;
    logic clr_step;
    logic sh_prime;
    logic sh_hold;
    logic sh_step;
    logic sh_tail;
    logic sc_read;
    logic sc_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    op_t  in_op;
    logic sh_empty;
    logic clr_done;
    logic row_end;
    logic last_row;
    logic col_last;
    logic out_free;
  } status_t;

  function automatic logic [COL_W-1:0] visible_cols(input logic [PANEL_W-1:0] panels);
    logic [COL_W-1:0] c;
    c = (panels >= PANEL_W'(2)) ? COL_W'(2 * PANEL_BYTES) : COL_W'(PANEL_BYTES);
    if (c > COL_W'(MAX_COLUMNS)) c = COL_W'(MAX_COLUMNS);
    return c;
  endfunction

  function automatic logic [ADDR_W-1:0] byte_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(STRIDE) + ADDR_W'(c);
  endfunction

  function automatic logic [BYTE_W-1:0] shift_byte(input logic [BYTE_W-1:0]   hi,
                                                   input logic [BYTE_W-1:0]   lo,
                                                   input logic [AMOUNT_W-1:0] n);
    logic [2*BYTE_W-1:0] pair;
    pair = {hi, lo} << n;
    return pair[2*BYTE_W-1:BYTE_W];
  endfunction

endpackage

@@ src/lmrs_if.sv @@
// Interfaces: input item channel, result channel and configuration write channel.
interface lmrs_item_if;
  logic                          valid;
  logic                          ready;
  logic [lmrs_pkg::OP_W-1:0]     operation;
  logic [lmrs_pkg::ROW_W-1:0]    row;
  logic [lmrs_pkg::STOP_W-1:0]   row_stop;
  logic [lmrs_pkg::COL_W-1:0]    column;
  logic [lmrs_pkg::BYTE_W-1:0]   value;
  logic [lmrs_pkg::AMOUNT_W-1:0] shift_amount;
  modport source (output valid, operation, row, row_stop, column, value, shift_amount,
                  input ready);
  modport sink (input valid, operation, row, row_stop, column, value, shift_amount,
                output ready);
endinterface

interface lmrs_result_if;
  logic                         valid;
  logic                         ready;
  logic [lmrs_pkg::BYTE_W-1:0]  pixel_byte;
  logic [lmrs_pkg::ROW_W-1:0]   row_address;
  logic [lmrs_pkg::INDEX_W-1:0] column_index;
  logic                         last;
  modport source (output valid, pixel_byte, row_address, column_index, last, input ready);
  modport sink (input valid, pixel_byte, row_address, column_index, last, output ready);
endinterface

interface lmrs_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lmrs_pkg::PANEL_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ src/lmrs_ctrl.sv @@
// Controller: state machine sequencing clear, shift and scan over the datapath.
module lmrs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  lmrs_pkg::status_t st,
  output lmrs_pkg::cmd_t    cmd,
  output logic              in_ready
);

  lmrs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lmrs_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lmrs_pkg::ST_CLEAR: begin
        if (st.clr_done) state_next = lmrs_pkg::ST_IDLE;
      end
      lmrs_pkg::ST_IDLE: begin
        if (st.in_valid) begin
          unique case (st.in_op)
            lmrs_pkg::OP_WRITE: state_next = lmrs_pkg::ST_IDLE;
            lmrs_pkg::OP_SHIFT: state_next = st.sh_empty ? lmrs_pkg::ST_IDLE
                                                         : lmrs_pkg::ST_SH_PRIME;
            lmrs_pkg::OP_SCAN:  state_next = lmrs_pkg::ST_SC_READ;
            lmrs_pkg::OP_CLEAR: state_next = lmrs_pkg::ST_CLEAR;
            default:            state_next = lmrs_pkg::ST_IDLE;
          endcase
        end
      end
      lmrs_pkg::ST_SH_PRIME: state_next = lmrs_pkg::ST_SH_HOLD;
      lmrs_pkg::ST_SH_HOLD:  state_next = lmrs_pkg::ST_SH_STEP;
      lmrs_pkg::ST_SH_STEP: begin
        if (st.row_end) state_next = lmrs_pkg::ST_SH_TAIL;
      end
      lmrs_pkg::ST_SH_TAIL: begin
        state_next = st.last_row ? lmrs_pkg::ST_IDLE : lmrs_pkg::ST_SH_PRIME;
      end
      lmrs_pkg::ST_SC_READ: state_next = lmrs_pkg::ST_SC_LOAD;
      lmrs_pkg::ST_SC_LOAD: begin
        if (st.out_free) begin
          state_next = st.col_last ? lmrs_pkg::ST_IDLE : lmrs_pkg::ST_SC_READ;
        end
      end
      default: state_next = lmrs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      lmrs_pkg::ST_CLEAR:    cmd.clr_step = 1'b1;
      lmrs_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.item_take = st.in_valid;
      end
      lmrs_pkg::ST_SH_PRIME: cmd.sh_prime = 1'b1;
      lmrs_pkg::ST_SH_HOLD:  cmd.sh_hold  = 1'b1;
      lmrs_pkg::ST_SH_STEP:  cmd.sh_step  = 1'b1;
      lmrs_pkg::ST_SH_TAIL:  cmd.sh_tail  = 1'b1;
      lmrs_pkg::ST_SC_READ:  cmd.sc_read  = 1'b1;
      lmrs_pkg::ST_SC_LOAD:  cmd.sc_load  = st.out_free;
      default: ;
    endcase
  end

endmodule

@@ src/lmrs_datapath.sv @@
// Datapath: frame store memory, row/column counters, shift unit and result register.
module lmrs_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  lmrs_pkg::cmd_t                   cmd,
  output lmrs_pkg::status_t                st,
  input  logic                             in_valid,
  input  logic [lmrs_pkg::OP_W-1:0]        operation,
  input  logic [lmrs_pkg::ROW_W-1:0]       row,
  input  logic [lmrs_pkg::STOP_W-1:0]      row_stop,
  input  logic [lmrs_pkg::COL_W-1:0]       column,
  input  logic [lmrs_pkg::BYTE_W-1:0]      value,
  input  logic [lmrs_pkg::AMOUNT_W-1:0]    shift_amount,
  lmrs_result_if.source                    result,
  lmrs_cfg_if.sink                         cfg
);

  localparam int ADDR_W = lmrs_pkg::ADDR_W;
  localparam int COL_W  = lmrs_pkg::COL_W;
  localparam int STOP_W = lmrs_pkg::STOP_W;
  localparam int BYTE_W = lmrs_pkg::BYTE_W;

  logic [BYTE_W-1:0] mem [lmrs_pkg::DEPTH];
  logic              mem_we;
  logic              rd_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] wr_data;
  logic [BYTE_W-1:0] rd_data;

  logic [ADDR_W-1:0]            clr_addr;
  logic [lmrs_pkg::ROW_W-1:0]   scan_row;
  logic [lmrs_pkg::ROW_W-1:0]   sh_row;
  logic [COL_W-1:0]             col;
  logic [lmrs_pkg::PANEL_W-1:0] panel_count;
  logic                         out_valid;
  logic [STOP_W-1:0]            sh_stop;
  logic [lmrs_pkg::AMOUNT_W-1:0] amount;
  logic [BYTE_W-1:0]            cur;
  logic [BYTE_W-1:0]            out_byte;
  logic [lmrs_pkg::ROW_W-1:0]   out_row;
  logic [lmrs_pkg::INDEX_W-1:0] out_index;
  logic                         out_last;

  logic [COL_W-1:0]  vis_cols;
  logic [STOP_W-1:0] stop_clip;
  logic              write_ok;

  assign vis_cols  = lmrs_pkg::visible_cols(panel_count);
  assign stop_clip = (row_stop > STOP_W'(lmrs_pkg::ROWS)) ? STOP_W'(lmrs_pkg::ROWS) : row_stop;
  assign write_ok  = (STOP_W'(row) < STOP_W'(lmrs_pkg::ROWS)) && (column <= vis_cols);

  assign st.in_valid = in_valid;
  assign st.in_op    = lmrs_pkg::op_t'(operation);
  assign st.sh_empty = STOP_W'(row) >= stop_clip;
  assign st.clr_done = clr_addr == ADDR_W'(lmrs_pkg::DEPTH - 1);
  assign st.row_end  = col == vis_cols;
  assign st.last_row = (STOP_W'(sh_row) + STOP_W'(1)) >= sh_stop;
  assign st.col_last = col == (vis_cols - COL_W'(1));
  assign st.out_free = !out_valid || result.ready;

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = lmrs_pkg::byte_addr(row, column);
    wr_data = value;
    priority if (cmd.clr_step) begin
      mem_we  = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (cmd.item_take && operation == lmrs_pkg::OP_WRITE && write_ok) begin
      mem_we  = 1'b1;
    end else if (cmd.sh_step) begin
      mem_we  = 1'b1;
      wr_addr = lmrs_pkg::byte_addr(sh_row, col - COL_W'(1));
      wr_data = lmrs_pkg::shift_byte(cur, rd_data, amount);
    end else if (cmd.sh_tail) begin
      mem_we  = 1'b1;
      wr_addr = lmrs_pkg::byte_addr(sh_row, col);
      wr_data = lmrs_pkg::shift_byte(cur, '0, amount);
    end
  end

  always_comb begin
    rd_en   = cmd.sh_prime || cmd.sh_hold || (cmd.sh_step && !st.row_end) || cmd.sc_read;
    rd_addr = lmrs_pkg::byte_addr(sh_row, col);
    priority if (cmd.sc_read) begin
      rd_addr = lmrs_pkg::byte_addr(scan_row, col);
    end else if (cmd.sh_step) begin
      rd_addr = lmrs_pkg::byte_addr(sh_row, col + COL_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr    <= '0;
      scan_row    <= '0;
      sh_row      <= '0;
      col         <= '0;
      panel_count <= lmrs_pkg::PANEL_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) panel_count <= cfg.data;
      if (cmd.clr_step) clr_addr <= clr_addr + ADDR_W'(1);
      if (cmd.item_take) begin
        unique case (lmrs_pkg::op_t'(operation))
          lmrs_pkg::OP_WRITE: ;
          lmrs_pkg::OP_SHIFT: begin
            sh_row <= row;
            col    <= '0;
          end
          lmrs_pkg::OP_SCAN:  col <= '0;
          lmrs_pkg::OP_CLEAR: begin
            clr_addr <= '0;
            scan_row <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.sh_prime || (cmd.sh_step && !st.row_end)) col <= col + COL_W'(1);
      if (cmd.sh_tail) begin
        sh_row <= sh_row + lmrs_pkg::ROW_W'(1);
        col    <= '0;
      end
      if (cmd.sc_load) begin
        col <= col + COL_W'(1);
        if (st.col_last) begin
          scan_row <= (scan_row == lmrs_pkg::ROW_W'(lmrs_pkg::ROWS - 1))
                      ? '0 : scan_row + lmrs_pkg::ROW_W'(1);
        end
      end
      if (cmd.sc_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_take) begin
      sh_stop <= stop_clip;
      amount  <= shift_amount;
    end
    if (cmd.sh_hold || cmd.sh_step) cur <= rd_data;
    if (cmd.sc_load) begin
      out_byte  <= rd_data;
      out_row   <= scan_row;
      out_index <= col[lmrs_pkg::INDEX_W-1:0];
      out_last  <= st.col_last;
    end
  end

  assign cfg.ready           = 1'b1;
  assign result.valid        = out_valid;
  assign result.pixel_byte   = out_byte;
  assign result.row_address  = out_row;
  assign result.column_index = out_index;
  assign result.last         = out_last;

  a_step_col: assert property (@(posedge clk) disable iff (rst)
    cmd.sh_step |-> (col != '0) && (col <= vis_cols))
    else $error("shift step outside row");

  a_load_col: assert property (@(posedge clk) disable iff (rst)
    cmd.sc_load |-> col < vis_cols)
    else $error("scan load past visible columns");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.sc_load |-> (!out_valid || result.ready))
    else $error("result register overwritten before transfer");

  a_scan_row: assert property (@(posedge clk) disable iff (rst)
    (scan_row != $past(scan_row)) |->
      ($past(cmd.sc_load && st.col_last) ||
       $past(cmd.item_take && operation == lmrs_pkg::OP_CLEAR)))
    else $error("scan row moved without end of row or clear");

endmodule

@@ src/led_matrix_row_scanner_unit.sv @@
// Top level: LED matrix row scanner with frame store, shift and scan operations.
// Items are taken one at a time, only while the controller is idle. A scan tick
// covers C = 8 or 16 visible bytes: each byte needs one registered read of the
// single-port-read frame store and one load of the result register, which holds a
// finished byte while the next item is accepted. A shift reads and rewrites every
// row byte by byte through the same memory. After reset and after each clear the
// store is swept with zeros, one byte per cycle, and no item is accepted during the
// sweep; configuration writes are taken at any time.
module led_matrix_row_scanner_unit (
  input  logic          clk,
  input  logic          rst,
  lmrs_item_if.sink     item,
  lmrs_result_if.source result,
  lmrs_cfg_if.sink      cfg
);

  lmrs_pkg::cmd_t    cmd;
  lmrs_pkg::status_t st;
  logic              in_ready;

  assign item.ready = in_ready;

  lmrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .st       (st),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  lmrs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .in_valid     (item.valid),
    .operation    (item.operation),
    .row          (item.row),
    .row_stop     (item.row_stop),
    .column       (item.column),
    .value        (item.value),
    .shift_amount (item.shift_amount),
    .result       (result),
    .cfg          (cfg)
  );

endmodule

@@ bench/lmrs_checker.sv @@
// Checker: frame store and scan predictor for the row scanner, compares every result transfer.
module lmrs_checker (
  input  logic   clk,
  input  logic   rst,
  lmrs_item_if   item,
  lmrs_result_if result,
  lmrs_cfg_if    cfg,
  output int     fail_count,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [lmrs_pkg::BYTE_W-1:0]  pixel;
    logic [lmrs_pkg::ROW_W-1:0]   row_addr;
    logic [lmrs_pkg::INDEX_W-1:0] col_idx;
    logic                         last;
  } scan_byte_t;

  logic [lmrs_pkg::BYTE_W-1:0]  frame_bytes [lmrs_pkg::ROWS][lmrs_pkg::STRIDE];
  logic [lmrs_pkg::ROW_W-1:0]   cur_scan_row;
  logic [lmrs_pkg::PANEL_W-1:0] panels;
  scan_byte_t                   scan_bytes_q [$];

  function automatic int unsigned shown_cols();
    int unsigned p;
    int unsigned c;
    p = panels;
    if (p < 1) p = 1;
    if (p > 2) p = 2;
    c = lmrs_pkg::PANEL_BYTES * p;
    if (c > lmrs_pkg::MAX_COLUMNS) c = lmrs_pkg::MAX_COLUMNS;
    return c;
  endfunction

  task automatic wipe_frame();
    for (int r = 0; r < lmrs_pkg::ROWS; r++) begin
      for (int c = 0; c < lmrs_pkg::STRIDE; c++) frame_bytes[r][c] = '0;
    end
    cur_scan_row = '0;
  endtask

  task automatic apply_frame_op(input lmrs_pkg::op_t op,
                                input logic [lmrs_pkg::ROW_W-1:0] row,
                                input logic [lmrs_pkg::STOP_W-1:0] row_stop,
                                input logic [lmrs_pkg::COL_W-1:0] column,
                                input logic [lmrs_pkg::BYTE_W-1:0] value,
                                input logic [lmrs_pkg::AMOUNT_W-1:0] amount);
    int unsigned cols;
    int unsigned stop_row;
    int unsigned next_row;
    logic [lmrs_pkg::BYTE_W-1:0] nbr;
    logic [2*lmrs_pkg::BYTE_W-1:0] pair;
    scan_byte_t sb;
    cols = shown_cols();
    case (op)
      lmrs_pkg::OP_WRITE: begin
        if (int'(row) < lmrs_pkg::ROWS && int'(column) <= cols) begin
          frame_bytes[row][column] = value;
        end
      end
      lmrs_pkg::OP_SHIFT: begin
        stop_row = (row_stop > lmrs_pkg::ROWS) ? lmrs_pkg::ROWS : row_stop;
        for (int unsigned r = row; r < stop_row; r++) begin
          // walk left to right so the right neighbor is still the old byte
          for (int unsigned c = 0; c <= cols; c++) begin
            nbr = (c < cols) ? frame_bytes[r][c+1] : '0;
            pair = {frame_bytes[r][c], nbr} << amount;
            frame_bytes[r][c] = pair[2*lmrs_pkg::BYTE_W-1:lmrs_pkg::BYTE_W];
          end
        end
      end
      lmrs_pkg::OP_SCAN: begin
        for (int unsigned k = 0; k < cols; k++) begin
          sb.pixel    = frame_bytes[cur_scan_row][k];
          sb.row_addr = cur_scan_row;
          sb.col_idx  = lmrs_pkg::INDEX_W'(k);
          sb.last     = (k + 1 == cols);
          scan_bytes_q.push_back(sb);
        end
        next_row = cur_scan_row + 1;
        if (next_row >= lmrs_pkg::ROWS) next_row = 0;
        cur_scan_row = lmrs_pkg::ROW_W'(next_row);
      end
      default: wipe_frame();
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    scan_byte_t want;
    if (rst) begin
      wipe_frame();
      panels = lmrs_pkg::PANEL_RESET;
      scan_bytes_q.delete();
      fail_count = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (scan_bytes_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0h row %0h col %0h last %0b",
                   $time, result.pixel_byte, result.row_address, result.column_index,
                   result.last);
          fail_count++;
        end else begin
          want = scan_bytes_q.pop_front();
          check_field("pixel_byte", want.pixel, result.pixel_byte);
          check_field("row_address", want.row_addr, result.row_address);
          check_field("column_index", want.col_idx, result.column_index);
          check_field("last", want.last, result.last);
        end
      end
      if (cfg.valid && cfg.ready) panels = cfg.data;
      if (item.valid && item.ready)
        apply_frame_op(lmrs_pkg::op_t'(item.operation), item.row, item.row_stop,
                       item.column, item.value, item.shift_amount);
    end
    pending = scan_bytes_q.size();
  end

endmodule

@@ bench/tb_top.sv @@
// Testbench top: clock, reset, stimulus, idling and verdict for the row scanner.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int SETTLE_CYCLES   = 400;
  localparam int PRESSURE_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  int   cur_cols;
  int   send_idle_pct;
  int   recv_stall_pct;
  logic hold_ready;

  lmrs_item_if   item_ch ();
  lmrs_result_if result_ch ();
  lmrs_cfg_if    cfg_ch ();

  led_matrix_row_scanner_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  lmrs_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .cfg        (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    result_ch.ready <= !hold_ready && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_op(input lmrs_pkg::op_t op, input int row, input int row_stop,
                         input int column, input int value, input int amount);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.operation    <= op;
    item_ch.row          <= lmrs_pkg::ROW_W'(row);
    item_ch.row_stop     <= lmrs_pkg::STOP_W'(row_stop);
    item_ch.column       <= lmrs_pkg::COL_W'(column);
    item_ch.value        <= lmrs_pkg::BYTE_W'(value);
    item_ch.shift_amount <= lmrs_pkg::AMOUNT_W'(amount);
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_op();
    int            pick;
    lmrs_pkg::op_t op;
    pick = $urandom_range(99);
    if (pick < 45)      op = lmrs_pkg::OP_WRITE;
    else if (pick < 66) op = lmrs_pkg::OP_SHIFT;
    else if (pick < 97) op = lmrs_pkg::OP_SCAN;
    else                op = lmrs_pkg::OP_CLEAR;
    send_op(op, $urandom_range(15),
            ($urandom_range(99) < 80) ? $urandom_range(16) : $urandom_range(31),
            ($urandom_range(99) < 85) ? $urandom_range(cur_cols) : $urandom_range(31),
            $urandom_range(255),
            ($urandom_range(99) < 80) ? $urandom_range(8) : $urandom_range(15));
  endtask

  task automatic drain_and_settle();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input int panel_val, input int idle_pct, input int stall_pct,
                           input int n_items, input bit pressure);
    drain_and_settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= lmrs_pkg::PANEL_W'(panel_val);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid   <= 1'b0;
    cur_cols       = (panel_val >= 2) ? 2 * lmrs_pkg::PANEL_BYTES : lmrs_pkg::PANEL_BYTES;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (pressure) begin
      fork
        begin
          hold_ready <= 1'b1;
          repeat (PRESSURE_CYCLES) @(negedge clk);
          hold_ready <= 1'b0;
        end
      join_none
    end
    repeat (n_items) send_random_op();
    item_ch.valid <= 1'b0;
  endtask

  initial begin
    item_ch.valid        = 1'b0;
    item_ch.operation    = lmrs_pkg::OP_WRITE;
    item_ch.row          = '0;
    item_ch.row_stop     = '0;
    item_ch.column       = '0;
    item_ch.value        = '0;
    item_ch.shift_amount = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.data          = '0;
    hold_ready           = 1'b0;
    cur_cols             = lmrs_pkg::PANEL_BYTES;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset panel count
    send_op(lmrs_pkg::OP_WRITE, 0, 0, 0, 8'hFF, 0);
    send_op(lmrs_pkg::OP_WRITE, 0, 0, 7, 8'h81, 0);
    send_op(lmrs_pkg::OP_WRITE, 0, 0, 8, 8'hA5, 0);    // spare column
    send_op(lmrs_pkg::OP_WRITE, 0, 0, 9, 8'h3C, 0);    // past spare, ignored
    send_op(lmrs_pkg::OP_WRITE, 1, 0, 31, 8'h55, 0);   // ignored
    send_op(lmrs_pkg::OP_WRITE, 1, 0, 0, 8'h80, 0);
    send_op(lmrs_pkg::OP_WRITE, 1, 0, 8, 8'hC3, 0);
    send_op(lmrs_pkg::OP_SCAN, 0, 0, 0, 0, 0);
    send_op(lmrs_pkg::OP_SHIFT, 1, 2, 0, 0, 3);
    send_op(lmrs_pkg::OP_SHIFT, 5, 5, 0, 0, 4);        // empty range
    send_op(lmrs_pkg::OP_SHIFT, 9, 3, 0, 0, 2);        // start past stop
    send_op(lmrs_pkg::OP_SCAN, 15, 31, 31, 8'hFF, 15);
    send_op(lmrs_pkg::OP_WRITE, 15, 0, 7, 8'hF0, 0);
    send_op(lmrs_pkg::OP_WRITE, 15, 0, 8, 8'h0F, 0);
    send_op(lmrs_pkg::OP_SHIFT, 14, 31, 0, 0, 8);      // stop clipped, full byte move
    send_op(lmrs_pkg::OP_SHIFT, 15, 16, 0, 0, 15);     // amount above eight
    send_op(lmrs_pkg::OP_SHIFT, 0, 16, 0, 0, 0);
    send_op(lmrs_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
    send_op(lmrs_pkg::OP_WRITE, 0, 0, 3, 8'h7E, 0);
    send_op(lmrs_pkg::OP_SCAN, 0, 0, 0, 0, 0);
    item_ch.valid <= 1'b0;

    run_phase(2, 0, 0, 90, 1'b0);
    run_phase(0, 57, 0, 80, 1'b0);
    run_phase(3, 0, 57, 80, 1'b1);
    run_phase(1, 20, 20, 80, 1'b0);
    run_phase(2, 0, 0, 80, 1'b0);

    drain_and_settle();
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/lmrs_pkg.sv
src/lmrs_if.sv
src/lmrs_ctrl.sv
src/lmrs_datapath.sv
src/led_matrix_row_scanner_unit.sv
bench/lmrs_checker.sv
bench/tb_top.sv
